// ----- sv/altc_pkg.sv -----
// Shared types, codes and sizes of the launch trigger capture block.
`timescale 1ns / 1ps
package altc_pkg;
    localparam int LOG_DEPTH   = 16384;
    localparam int PRE_DEPTH   = 2048;
    localparam int SAMPLE_BITS = 13;
    localparam int PRE_CAP     = (PRE_DEPTH < LOG_DEPTH) ? PRE_DEPTH : LOG_DEPTH;
    localparam int PTR_W       = $clog2(LOG_DEPTH);
    localparam int LVL_W       = PTR_W + 1;
    localparam int PRE_W       = $clog2(PRE_CAP + 1);
    localparam int PACK_W      = 3 * SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int MAG_W       = 26;
    localparam int MS_W        = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 26;
    localparam logic [9:0] FLIGHT_LAST = 10'd999;

    typedef enum logic [2:0] {
        OP_SAMPLE  = 3'd0,
        OP_TICK    = 3'd1,
        OP_WAKE    = 3'd2,
        OP_MANUAL  = 3'd3,
        OP_XFER_IN = 3'd4,
        OP_XFER_EX = 3'd5,
        OP_READ    = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_SQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_SQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_XFER_MS   = 3'd6;

    localparam logic [2:0] MODE_SLEEP  = 3'd0;
    localparam logic [2:0] MODE_ACTIVE = 3'd1;
    localparam logic [2:0] MODE_LOG    = 3'd2;
    localparam logic [2:0] MODE_COOL   = 3'd3;
    localparam logic [2:0] MODE_XFER   = 3'd4;

    typedef struct packed {
        logic [MAG_W-1:0] launch_level_sq;
        logic [MAG_W-1:0] quiet_level_sq;
        logic [15:0]      launch_hold;
        logic [MS_W-1:0]  quiet_ms;
        logic [MS_W-1:0]  record_ms;
        logic [MS_W-1:0]  cooldown_ms;
        logic [MS_W-1:0]  transfer_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        op;
        logic [PACK_W-1:0] sample;
        logic              above_quiet;
        logic              above_launch;
    } t_item;

    typedef struct packed {
        logic [2:0]             mode;
        logic                   log_valid;
        logic [SAMPLE_BITS-1:0] log_x;
        logic [SAMPLE_BITS-1:0] log_y;
        logic [SAMPLE_BITS-1:0] log_z;
        logic [LVL_W-1:0]       queue_level;
        logic [31:0]            dropped;
        logic [15:0]            flights;
        logic [9:0]             flight_number;
    } t_result;
endpackage

// ----- sv/altc_front.sv -----
// Front end: takes items, squares the axes and classifies samples against the thresholds.
`timescale 1ns / 1ps
module altc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [2:0]                         i_operation,
    input  logic signed [altc_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [altc_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [altc_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  altc_pkg::t_cfg                     i_cfg,
    input  logic                               i_full,
    output logic                               o_push,
    output altc_pkg::t_item                    o_item
);
    import altc_pkg::*;

    logic                   r_valid;
    logic [2:0]             r_op;
    logic [PACK_W-1:0]      r_sample;
    logic [SQ_W-1:0]        r_sqx, r_sqy, r_sqz;
    logic [SAMPLE_BITS-1:0] ax, ay, az;
    logic [MAG_W-1:0]       mag;
    logic                   take;

    function automatic logic [SAMPLE_BITS-1:0] abs_of(input logic [SAMPLE_BITS-1:0] v);
        abs_of = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    assign ax = abs_of(i_accel_x);
    assign ay = abs_of(i_accel_y);
    assign az = abs_of(i_accel_z);

    assign o_stall = r_valid && i_full;
    assign take    = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;

    assign mag = MAG_W'(r_sqx) + MAG_W'(r_sqy) + MAG_W'(r_sqz);
    assign o_item.op           = r_op;
    assign o_item.sample       = r_sample;
    assign o_item.above_quiet  = mag > i_cfg.quiet_level_sq;
    assign o_item.above_launch = mag > i_cfg.launch_level_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op     <= i_operation;
            r_sample <= {i_accel_z, i_accel_y, i_accel_x};
            r_sqx    <= SQ_W'(ax) * SQ_W'(ax);
            r_sqy    <= SQ_W'(ay) * SQ_W'(ay);
            r_sqz    <= SQ_W'(az) * SQ_W'(az);
        end
    end
endmodule

// ----- sv/altc_queue.sv -----
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
module altc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  altc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output altc_pkg::t_item o_item
);
    import altc_pkg::*;

    localparam int QD = 4;
    t_item      r_mem [QD];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    assign o_full     = r_cnt == 3'(QD);
    assign o_nonempty = r_cnt != 3'd0;
    assign o_item     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end
endmodule

// ----- sv/altc_back.sv -----
// Back end: mode sequencer, sample store, log queue pointers and result buffer.
`timescale 1ns / 1ps
module altc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  altc_pkg::t_cfg    i_cfg,
    input  logic              i_nonempty,
    input  altc_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output altc_pkg::t_result o_result
);
    import altc_pkg::*;

    typedef enum logic [4:0] {
        S_SLEEP  = 5'b00001,
        S_ACTIVE = 5'b00010,
        S_LOG    = 5'b00100,
        S_COOL   = 5'b01000,
        S_XFER   = 5'b10000
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [PTR_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [LVL_W-1:0]  r_held, n_held;
    logic [PRE_W-1:0]  r_pre, n_pre;
    logic [15:0]       r_run, n_run;
    logic [MS_W-1:0]   r_quiet, n_quiet, r_phase, n_phase;
    logic [31:0]       r_drop, n_drop;
    logic [15:0]       r_ftot, n_ftot;
    logic [9:0]        r_fidx, n_fidx;
    logic              r_tpend, n_tpend;
    logic              wr_en, rd_en;
    logic [MS_W:0]     tick_sum;

    logic [PACK_W-1:0] r_mem [LOG_DEPTH];
    logic [PACK_W-1:0] r_rdata;

    // Stage after the state update; read data of the store arrives with it.
    logic              r_s1_valid;
    t_result           r_s1;
    t_result           s1_full;

    localparam int OD = 3;
    t_result           r_obuf [OD];
    logic [1:0]        r_owr, r_ord;
    logic [1:0]        r_ocnt;
    logic              opop;

    function automatic logic [2:0] mode_code(input t_mode m);
        case (m)
            S_SLEEP:  mode_code = MODE_SLEEP;
            S_ACTIVE: mode_code = MODE_ACTIVE;
            S_LOG:    mode_code = MODE_LOG;
            S_COOL:   mode_code = MODE_COOL;
            S_XFER:   mode_code = MODE_XFER;
            default:  mode_code = MODE_SLEEP;
        endcase
    endfunction

    function automatic logic [9:0] fnext(input logic [9:0] f);
        fnext = (f >= FLIGHT_LAST) ? 10'd0 : f + 10'd1;
    endfunction

    assign o_pop = i_nonempty && ((2'(r_s1_valid) + r_ocnt) <= 2'd2);

    always_comb begin
        n_mode   = r_mode;
        n_head   = r_head;
        n_tail   = r_tail;
        n_held   = r_held;
        n_pre    = r_pre;
        n_run    = r_run;
        n_quiet  = r_quiet;
        n_phase  = r_phase;
        n_drop   = r_drop;
        n_ftot   = r_ftot;
        n_fidx   = r_fidx;
        n_tpend  = r_tpend;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        tick_sum = '0;
        if (o_pop) begin
            case (t_op'(i_item.op))
                OP_SAMPLE: begin
                    if (r_mode == S_ACTIVE) begin
                        wr_en  = 1'b1;
                        n_head = r_head + 1'b1;
                        if (r_pre < PRE_W'(PRE_CAP)) n_pre = r_pre + 1'b1;
                        if (i_item.above_quiet) n_quiet = '0;
                        if (i_item.above_launch) begin
                            if (r_run != 16'hFFFF) n_run = r_run + 16'd1;
                            if (n_run >= i_cfg.launch_hold) begin
                                n_tail  = n_head - PTR_W'(n_pre);
                                n_held  = LVL_W'(n_pre);
                                n_pre   = '0;
                                n_run   = '0;
                                n_phase = '0;
                                n_mode  = S_LOG;
                                if (r_ftot != 16'hFFFF) n_ftot = r_ftot + 16'd1;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end else if (r_mode == S_LOG) begin
                        if (r_held < LVL_W'(LOG_DEPTH)) begin
                            wr_en  = 1'b1;
                            n_head = r_head + 1'b1;
                            n_held = r_held + 1'b1;
                            n_drop = '0;
                        end else if (r_drop != 32'hFFFF_FFFF) begin
                            n_drop = r_drop + 32'd1;
                        end
                    end
                end
                OP_TICK: begin
                    case (r_mode)
                        S_ACTIVE: begin
                            tick_sum = {1'b0, r_quiet} + 1'b1;
                            if (tick_sum > {1'b0, i_cfg.quiet_ms}) begin
                                n_mode  = S_SLEEP;
                                n_run   = '0;
                                n_quiet = '0;
                            end else begin
                                n_quiet = tick_sum[MS_W-1:0];
                            end
                        end
                        S_LOG: begin
                            tick_sum = {1'b0, r_phase} + 1'b1;
                            if (tick_sum >= {1'b0, i_cfg.record_ms}) begin
                                n_mode  = S_COOL;
                                n_phase = '0;
                            end else begin
                                n_phase = tick_sum[MS_W-1:0];
                            end
                        end
                        S_COOL: begin
                            if (r_held == '0 && r_phase < i_cfg.cooldown_ms)
                                n_phase = r_phase + 1'b1;
                        end
                        S_XFER: begin
                            tick_sum = {1'b0, r_phase} + 1'b1;
                            if (tick_sum >= {1'b0, i_cfg.transfer_limit_ms}) begin
                                if (r_tpend) n_fidx = fnext(r_fidx);
                                n_tpend = 1'b0;
                                n_tail  = r_head;
                                n_held  = '0;
                                n_run   = '0;
                                n_phase = '0;
                                n_quiet = '0;
                                n_mode  = S_SLEEP;
                            end else begin
                                n_phase = tick_sum[MS_W-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
                OP_WAKE: begin
                    if (r_mode == S_SLEEP) begin
                        n_mode  = S_ACTIVE;
                        n_quiet = '0;
                    end
                end
                OP_MANUAL: begin
                    if (r_mode == S_SLEEP || r_mode == S_ACTIVE) begin
                        n_tail  = r_head - PTR_W'(r_pre);
                        n_held  = LVL_W'(r_pre);
                        n_pre   = '0;
                        n_run   = '0;
                        n_phase = '0;
                        n_mode  = S_LOG;
                        if (r_ftot != 16'hFFFF) n_ftot = r_ftot + 16'd1;
                    end
                end
                OP_XFER_IN: begin
                    if (r_mode == S_LOG || r_mode == S_COOL) n_tpend = 1'b1;
                    n_mode  = S_XFER;
                    n_phase = '0;
                end
                OP_XFER_EX: begin
                    if (r_mode == S_XFER) begin
                        if (r_tpend) n_fidx = fnext(r_fidx);
                        n_tpend = 1'b0;
                        n_tail  = r_head;
                        n_held  = '0;
                        n_run   = '0;
                        n_phase = '0;
                        n_quiet = '0;
                        n_mode  = S_SLEEP;
                    end
                end
                OP_READ: begin
                    if (r_held != '0) begin
                        rd_en  = 1'b1;
                        n_tail = r_tail + 1'b1;
                        n_held = r_held - 1'b1;
                    end
                end
                default: ;
            endcase
            if (n_mode == S_COOL && n_held == '0 && n_phase >= i_cfg.cooldown_ms) begin
                n_fidx  = fnext(n_fidx);
                n_head  = '0;
                n_tail  = '0;
                n_held  = '0;
                n_pre   = '0;
                n_run   = '0;
                n_phase = '0;
                n_quiet = '0;
                n_mode  = S_SLEEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_SLEEP;
            r_head  <= '0;
            r_tail  <= '0;
            r_held  <= '0;
            r_pre   <= '0;
            r_run   <= '0;
            r_quiet <= '0;
            r_phase <= '0;
            r_drop  <= '0;
            r_ftot  <= '0;
            r_fidx  <= '0;
            r_tpend <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_held  <= n_held;
            r_pre   <= n_pre;
            r_run   <= n_run;
            r_quiet <= n_quiet;
            r_phase <= n_phase;
            r_drop  <= n_drop;
            r_ftot  <= n_ftot;
            r_fidx  <= n_fidx;
            r_tpend <= n_tpend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_head] <= i_item.sample;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= r_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1.mode          <= mode_code(n_mode);
            r_s1.log_valid     <= rd_en;
            r_s1.log_x         <= '0;
            r_s1.log_y         <= '0;
            r_s1.log_z         <= '0;
            r_s1.queue_level   <= n_held;
            r_s1.dropped       <= n_drop;
            r_s1.flights       <= n_ftot;
            r_s1.flight_number <= n_fidx;
        end
    end

    always_comb begin
        s1_full = r_s1;
        if (r_s1.log_valid) begin
            s1_full.log_x = r_rdata[SAMPLE_BITS-1:0];
            s1_full.log_y = r_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            s1_full.log_z = r_rdata[PACK_W-1:2*SAMPLE_BITS];
        end
    end

    assign o_valid  = r_ocnt != 2'd0;
    assign o_result = r_obuf[r_ord];
    assign opop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_s1_valid) r_owr <= (r_owr == 2'(OD - 1)) ? 2'd0 : r_owr + 2'd1;
            if (opop)       r_ord <= (r_ord == 2'(OD - 1)) ? 2'd0 : r_ord + 2'd1;
            r_ocnt <= r_ocnt + 2'(r_s1_valid) - 2'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) r_obuf[r_owr] <= s1_full;
    end
endmodule

// ----- sv/accel_launch_trigger_capture_top.sv -----
// Top level of the launch trigger capture block: configuration registers and the two halves.
`timescale 1ns / 1ps
// The block takes one item per clock cycle in steady state while i_stall is low, and returns
// exactly one result transfer for every input transfer, in order. Each item passes a squaring
// stage in the front end, a four-entry queue, the mode sequencer with its single-port sample
// store, and a registered store read before it reaches a three-entry result buffer. One store
// access per item (a write for a logged sample or a read for a log pop) sets the rate of one
// item per cycle. Either side may stall on its own; the queue and the result buffer absorb the
// difference. The user must write configuration registers through the plain write port only
// while no transfer is in flight; the block itself does not enforce this. The sample store
// needs no clearing after reset, since no entry is read before it has been written.
module accel_launch_trigger_capture_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [2:0]                              i_operation,
    input  logic signed [altc_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [altc_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [altc_pkg::SAMPLE_BITS-1:0] i_accel_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [2:0]                              o_mode,
    output logic                                    o_log_valid,
    output logic signed [altc_pkg::SAMPLE_BITS-1:0] o_log_x,
    output logic signed [altc_pkg::SAMPLE_BITS-1:0] o_log_y,
    output logic signed [altc_pkg::SAMPLE_BITS-1:0] o_log_z,
    output logic [altc_pkg::LVL_W-1:0]              o_queue_level,
    output logic [31:0]                             o_dropped,
    output logic [15:0]                             o_flights,
    output logic [9:0]                              o_flight_number,
    input  logic                                    i_cfg_we,
    input  logic [altc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [altc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import altc_pkg::*;

    t_cfg    r_cfg;
    t_item   front_item, q_item;
    logic    q_full, q_push, q_nonempty, q_pop;
    t_result res;

    // Configuration registers; writes to indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_level_sq   <= MAG_W'(3721);
            r_cfg.quiet_level_sq    <= MAG_W'(1681);
            r_cfg.launch_hold       <= 16'd40;
            r_cfg.quiet_ms          <= MS_W'(5000);
            r_cfg.record_ms         <= MS_W'(60000);
            r_cfg.cooldown_ms       <= MS_W'(3000);
            r_cfg.transfer_limit_ms <= MS_W'(30000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LAUNCH_SQ: r_cfg.launch_level_sq   <= i_cfg_data[MAG_W-1:0];
                REG_QUIET_SQ:  r_cfg.quiet_level_sq    <= i_cfg_data[MAG_W-1:0];
                REG_HOLD:      r_cfg.launch_hold       <= i_cfg_data[15:0];
                REG_QUIET_MS:  r_cfg.quiet_ms          <= i_cfg_data[MS_W-1:0];
                REG_RECORD_MS: r_cfg.record_ms         <= i_cfg_data[MS_W-1:0];
                REG_COOL_MS:   r_cfg.cooldown_ms       <= i_cfg_data[MS_W-1:0];
                REG_XFER_MS:   r_cfg.transfer_limit_ms <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    altc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_cfg       (r_cfg),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_item      (front_item)
    );

    altc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (front_item),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_item     (q_item)
    );

    altc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_nonempty (q_nonempty),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (res)
    );

    assign o_mode          = res.mode;
    assign o_log_valid     = res.log_valid;
    assign o_log_x         = res.log_x;
    assign o_log_y         = res.log_y;
    assign o_log_z         = res.log_z;
    assign o_queue_level   = res.queue_level;
    assign o_dropped       = res.dropped;
    assign o_flights       = res.flights;
    assign o_flight_number = res.flight_number;
endmodule
